### src/jsu_pkg.sv
package jsu_pkg;

    // symbol codes, two's complement
    localparam logic signed [1:0] SYM_POS  = 2'sb01;
    localparam logic signed [1:0] SYM_ZERO = 2'sb00;
    localparam logic signed [1:0] SYM_NEG  = 2'sb11;

    // residues that flip the sign
    localparam logic [2:0] MOD8_THREE = 3'd3;
    localparam logic [2:0] MOD8_FIVE  = 3'd5;
    localparam logic [1:0] MOD4_THREE = 2'd3;

    typedef struct packed {
        logic load;
        logic halve;
        logic swap;
        logic mod_step;
        logic finish;
    } jsu_cmd_t;

    typedef struct packed {
        logic bad;
        logic a_zero;
        logic a_even;
        logic cnt_zero;
    } jsu_status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_TEST = 3'b010,
        S_MOD  = 3'b100
    } jsu_state_t;

endpackage

### src/jacobi_symbol_unit_top.sv
// Jacobi symbol (a/n) of two unsigned operands, one item at a time. The low
// OPERAND_WIDTH bits of each operand are used. Each factor of two is removed
// from a by one halving step, and each reciprocity round takes a mod n through
// a one-bit-per-cycle restoring remainder unit; rejected operands (n even, n
// below 3, a above n) finish with bad_operands set and symbol +1. A finished
// result sits in an output register, and the next operand beat is taken while
// it waits.
module jacobi_symbol_unit_top
    import jsu_pkg::*;
#(
    parameter int OPERAND_WIDTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [63:0]        operand_a,
    input  logic [63:0]        modulus_n,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [1:0]  symbol,
    output logic               bad_operands
);

    jsu_cmd_t    cmd;
    jsu_status_t status;

    jsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    jsu_dp #(
        .W (OPERAND_WIDTH)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .operand_a    (operand_a[OPERAND_WIDTH-1:0]),
        .modulus_n    (modulus_n[OPERAND_WIDTH-1:0]),
        .status       (status),
        .symbol       (symbol),
        .bad_operands (bad_operands)
    );

endmodule

### src/jsu_dp.sv
module jsu_dp
    import jsu_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic                clk,
    input  jsu_cmd_t            cmd,
    input  logic [W-1:0]        operand_a,
    input  logic [W-1:0]        modulus_n,
    output jsu_status_t         status,
    output logic signed [1:0]   symbol,
    output logic                bad_operands
);

    localparam int CW = $clog2(W);

    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        n_reg, n_next;
    logic [W-1:0]        r_reg, r_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic                bad_reg, bad_next;
    logic signed [1:0]   sym_reg, sym_next;
    logic                bado_reg, bado_next;

    logic [W:0]          rem_shift;
    logic                rem_ge;
    logic [W-1:0]        rem_new;

    // one restoring step of a mod n, dividend shifted out of a_reg msb first
    assign rem_shift = {r_reg, a_reg[W-1]};
    assign rem_ge    = rem_shift >= {1'b0, n_reg};
    assign rem_new   = rem_ge ? W'(rem_shift - {1'b0, n_reg}) : rem_shift[W-1:0];

    always_comb
    begin
        a_next    = a_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        bad_next  = bad_reg;
        sym_next  = sym_reg;
        bado_next = bado_reg;
        if (cmd.load)
        begin
            a_next   = operand_a;
            n_next   = modulus_n;
            neg_next = 1'b0;
            bad_next = !modulus_n[0] || (modulus_n < W'(3)) || (operand_a > modulus_n);
        end
        if (cmd.halve)
        begin
            a_next = a_reg >> 1;
            if (n_reg[2:0] == MOD8_THREE || n_reg[2:0] == MOD8_FIVE)
                neg_next = !neg_reg;
        end
        if (cmd.swap)
        begin
            a_next   = n_reg;
            n_next   = a_reg;
            r_next   = '0;
            cnt_next = CW'(W - 1);
            if (a_reg[1:0] == MOD4_THREE && n_reg[1:0] == MOD4_THREE)
                neg_next = !neg_reg;
        end
        if (cmd.mod_step)
        begin
            r_next   = rem_new;
            cnt_next = cnt_reg - 1'b1;
            a_next   = (cnt_reg == '0) ? rem_new : (a_reg << 1);
        end
        if (cmd.finish)
        begin
            bado_next = bad_reg;
            if (bad_reg)
                sym_next = SYM_POS;
            else if (n_reg == W'(1))
                sym_next = neg_reg ? SYM_NEG : SYM_POS;
            else
                sym_next = SYM_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        n_reg    <= n_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        bad_reg  <= bad_next;
        sym_reg  <= sym_next;
        bado_reg <= bado_next;
    end

    assign status.bad      = bad_reg;
    assign status.a_zero   = (a_reg == '0);
    assign status.a_even   = !a_reg[0];
    assign status.cnt_zero = (cnt_reg == '0);

    assign symbol       = sym_reg;
    assign bad_operands = bado_reg;

endmodule

### src/jsu_ctrl.sv
module jsu_ctrl
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  jsu_status_t  status,
    output jsu_cmd_t     cmd
);

    jsu_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       can_finish;

    assign can_finish = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (status.bad || status.a_zero)
                begin
                    // wait for the output register to be free
                    if (can_finish)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (status.a_even)
                    cmd.halve = 1'b1;
                else
                begin
                    cmd.swap   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.cnt_zero)
                    state_next = S_TEST;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.finish)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

endmodule

### src/jsu_checker.sv
module jsu_checker
    import jsu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [1:0]  symbol,
    input  logic               bad_operands
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(bad_operands))
        else $error("result beat changed while stalled");

    // rejected operands always report +1
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_operands |-> symbol == SYM_POS)
        else $error("bad operands without symbol +1");

    // only -1, 0, +1 ever appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> symbol == SYM_POS || symbol == SYM_ZERO || symbol == SYM_NEG)
        else $error("illegal symbol code");

    // one item in flight: no new beat right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

endmodule

bind jacobi_symbol_unit_top jsu_checker u_jsu_checker (.*);
